// ===== sv/segment_intersection_xy_defines.svh =====
// assertion macros for segment_intersection_xy
`ifndef SEGMENT_INTERSECTION_XY_DEFINES_SVH
`define SEGMENT_INTERSECTION_XY_DEFINES_SVH
`ifndef SYNTHESIS
`define SIX_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SIX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SIX_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SIX_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/six_pkg.sv =====
`timescale 1ns / 1ps
package six_pkg;
   localparam int COORD_BITS = 16;
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;
   localparam int MAG_BITS = CROSS_BITS;
   localparam int DEN_BITS = MAG_BITS + 1;
   localparam int NUM_BITS = MAG_BITS + DIFF_BITS;
   localparam int QUO_BITS = DIFF_BITS;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_ABITS = 2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0] diff_type;
   typedef logic signed [CROSS_BITS-1:0] cross_type;

   typedef struct packed {
      logic hit;
      coord_type ax;
      coord_type ay;
      logic [DIFF_BITS-1:0] mag_x;
      logic neg_x;
      logic [DIFF_BITS-1:0] mag_y;
      logic neg_y;
      logic [MAG_BITS-1:0] w;
      logic [DEN_BITS-1:0] den;
   } job_type;

   typedef struct packed {
      logic valid;
      logic hit;
      coord_type x;
      coord_type y;
   } res_type;
endpackage

// ===== sv/six_front.sv =====
`timescale 1ns / 1ps
module six_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  six_pkg::coord_type ax0,
   input  six_pkg::coord_type ay0,
   input  six_pkg::coord_type ax1,
   input  six_pkg::coord_type ay1,
   input  six_pkg::coord_type bx0,
   input  six_pkg::coord_type by0,
   input  six_pkg::coord_type bx1,
   input  six_pkg::coord_type by1,
   output logic out_valid,
   output six_pkg::job_type out_job
);
   import six_pkg::*;

   // stage 1: differences
   logic v1_ff;
   diff_type adx_ff, ady_ff, bdx_ff, bdy_ff;
   diff_type rb0x_ff, rb0y_ff, rb1x_ff, rb1y_ff;
   diff_type ra0x_ff, ra0y_ff, ra1x_ff, ra1y_ff;
   coord_type ax_s1_ff, ay_s1_ff;

   // stage 2: products
   logic v2_ff;
   logic signed [PROD_BITS-1:0] p_ff [8];
   coord_type ax_s2_ff, ay_s2_ff;
   diff_type adx_s2_ff, ady_s2_ff;

   // stage 3: classify
   logic v3_ff;
   job_type job_ff;

   function automatic diff_type sub_c(input coord_type a, input coord_type b);
      return diff_type'(a) - diff_type'(b);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      adx_ff <= sub_c(ax1, ax0);
      ady_ff <= sub_c(ay1, ay0);
      bdx_ff <= sub_c(bx1, bx0);
      bdy_ff <= sub_c(by1, by0);
      rb0x_ff <= sub_c(bx0, ax0);
      rb0y_ff <= sub_c(by0, ay0);
      rb1x_ff <= sub_c(bx1, ax0);
      rb1y_ff <= sub_c(by1, ay0);
      ra0x_ff <= sub_c(ax0, bx0);
      ra0y_ff <= sub_c(ay0, by0);
      ra1x_ff <= sub_c(ax1, bx0);
      ra1y_ff <= sub_c(ay1, by0);
      ax_s1_ff <= ax0;
      ay_s1_ff <= ay0;
   end

   always_ff @(posedge clock) begin
      p_ff[0] <= rb0y_ff * adx_ff;
      p_ff[1] <= rb0x_ff * ady_ff;
      p_ff[2] <= rb1y_ff * adx_ff;
      p_ff[3] <= rb1x_ff * ady_ff;
      p_ff[4] <= ra0y_ff * bdx_ff;
      p_ff[5] <= ra0x_ff * bdy_ff;
      p_ff[6] <= ra1y_ff * bdx_ff;
      p_ff[7] <= ra1x_ff * bdy_ff;
      ax_s2_ff <= ax_s1_ff;
      ay_s2_ff <= ay_s1_ff;
      adx_s2_ff <= adx_ff;
      ady_s2_ff <= ady_ff;
   end

   cross_type db0, db1, da0, da1;
   logic [MAG_BITS-1:0] m0, m1;
   job_type job_in;

   always_comb begin
      db0 = cross_type'(p_ff[0]) - cross_type'(p_ff[1]);
      db1 = cross_type'(p_ff[2]) - cross_type'(p_ff[3]);
      da0 = cross_type'(p_ff[4]) - cross_type'(p_ff[5]);
      da1 = cross_type'(p_ff[6]) - cross_type'(p_ff[7]);
      m0 = da0[CROSS_BITS-1] ? MAG_BITS'(-da0) : MAG_BITS'(da0);
      m1 = da1[CROSS_BITS-1] ? MAG_BITS'(-da1) : MAG_BITS'(da1);
      job_in.hit = ((db0 > 0) != (db1 > 0)) && ((da0 > 0) != (da1 > 0));
      job_in.ax = ax_s2_ff;
      job_in.ay = ay_s2_ff;
      job_in.neg_x = adx_s2_ff[DIFF_BITS-1];
      job_in.neg_y = ady_s2_ff[DIFF_BITS-1];
      job_in.mag_x = adx_s2_ff[DIFF_BITS-1] ? DIFF_BITS'(-adx_s2_ff) : adx_s2_ff;
      job_in.mag_y = ady_s2_ff[DIFF_BITS-1] ? DIFF_BITS'(-ady_s2_ff) : ady_s2_ff;
      job_in.w = m0;
      job_in.den = DEN_BITS'(m0) + DEN_BITS'(m1);
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign out_valid = v3_ff;
   assign out_job = job_ff;
endmodule

// ===== sv/six_queue.sv =====
`timescale 1ns / 1ps
module six_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  six_pkg::job_type push_job,
   input  logic pop,
   output logic not_empty,
   output six_pkg::job_type head_job
);
   import six_pkg::*;

   job_type mem_ff [QUEUE_DEPTH];
   logic [QUEUE_ABITS-1:0] wr_ff, rd_ff;
   logic [QUEUE_ABITS:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (QUEUE_ABITS+1)'(push) - (QUEUE_ABITS+1)'(pop);
      end
   end

   assign not_empty = cnt_ff != '0;
   assign head_job = mem_ff[rd_ff];
endmodule

// ===== sv/six_back.sv =====
`timescale 1ns / 1ps
module six_back (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  six_pkg::job_type in_job,
   output six_pkg::res_type res
);
   import six_pkg::*;

   // the weight is up to 35 bits; split into two partial products
   localparam int LO_BITS = MAG_BITS / 2;
   localparam int STEPS = QUO_BITS;

   logic [NUM_BITS-1:0] px_lo, px_hi, py_lo, py_hi;

   always_comb begin
      px_lo = NUM_BITS'(in_job.w[LO_BITS-1:0]) * NUM_BITS'(in_job.mag_x);
      px_hi = NUM_BITS'(in_job.w[MAG_BITS-1:LO_BITS]) * NUM_BITS'(in_job.mag_x);
      py_lo = NUM_BITS'(in_job.w[LO_BITS-1:0]) * NUM_BITS'(in_job.mag_y);
      py_hi = NUM_BITS'(in_job.w[MAG_BITS-1:LO_BITS]) * NUM_BITS'(in_job.mag_y);
   end

   // restoring divider, one quotient bit per stage
   logic sv_ff [STEPS+1];
   logic sh_ff [STEPS+1], snx_ff [STEPS+1], sny_ff [STEPS+1];
   coord_type sax_ff [STEPS+1], say_ff [STEPS+1];
   logic [NUM_BITS-1:0] rx_ff [STEPS+1], ry_ff [STEPS+1];
   logic [QUO_BITS-1:0] qx_ff [STEPS+1], qy_ff [STEPS+1];
   logic [DEN_BITS-1:0] sd_ff [STEPS+1];

   // stage 0: numerators
   always_ff @(posedge clock) begin
      if (reset) sv_ff[0] <= 1'b0;
      else sv_ff[0] <= in_valid;
   end

   always_ff @(posedge clock) begin
      sh_ff[0] <= in_job.hit && (in_job.den != '0);
      snx_ff[0] <= in_job.neg_x;
      sny_ff[0] <= in_job.neg_y;
      sax_ff[0] <= in_job.ax;
      say_ff[0] <= in_job.ay;
      rx_ff[0] <= px_lo + (px_hi << LO_BITS);
      ry_ff[0] <= py_lo + (py_hi << LO_BITS);
      qx_ff[0] <= '0;
      qy_ff[0] <= '0;
      sd_ff[0] <= in_job.den;
   end

   for (genvar g = 0; g < STEPS; g++) begin : g_div
      localparam int SH = STEPS - 1 - g;
      logic [NUM_BITS+QUO_BITS-1:0] dsx, dsy;
      logic gex, gey;
      always_comb begin
         dsx = (NUM_BITS+QUO_BITS)'(sd_ff[g]) << SH;
         dsy = dsx;
         gex = (NUM_BITS+QUO_BITS)'(rx_ff[g]) >= dsx;
         gey = (NUM_BITS+QUO_BITS)'(ry_ff[g]) >= dsy;
      end
      always_ff @(posedge clock) begin
         if (reset) sv_ff[g+1] <= 1'b0;
         else sv_ff[g+1] <= sv_ff[g];
      end
      always_ff @(posedge clock) begin
         sh_ff[g+1] <= sh_ff[g];
         snx_ff[g+1] <= snx_ff[g];
         sny_ff[g+1] <= sny_ff[g];
         sax_ff[g+1] <= sax_ff[g];
         say_ff[g+1] <= say_ff[g];
         sd_ff[g+1] <= sd_ff[g];
         rx_ff[g+1] <= gex ? NUM_BITS'((NUM_BITS+QUO_BITS)'(rx_ff[g]) - dsx) : rx_ff[g];
         ry_ff[g+1] <= gey ? NUM_BITS'((NUM_BITS+QUO_BITS)'(ry_ff[g]) - dsy) : ry_ff[g];
         qx_ff[g+1] <= qx_ff[g] | (QUO_BITS'(gex) << SH);
         qy_ff[g+1] <= qy_ff[g] | (QUO_BITS'(gey) << SH);
      end
   end

   res_type res_ff;
   coord_type qxc, qyc;

   always_comb begin
      qxc = coord_type'(qx_ff[STEPS]);
      qyc = coord_type'(qy_ff[STEPS]);
   end

   always_ff @(posedge clock) begin
      if (reset) res_ff.valid <= 1'b0;
      else res_ff.valid <= sv_ff[STEPS];
      res_ff.hit <= sh_ff[STEPS];
      res_ff.x <= !sh_ff[STEPS] ? '0 :
                  snx_ff[STEPS] ? sax_ff[STEPS] - qxc : sax_ff[STEPS] + qxc;
      res_ff.y <= !sh_ff[STEPS] ? '0 :
                  sny_ff[STEPS] ? say_ff[STEPS] - qyc : say_ff[STEPS] + qyc;
   end

   assign res = res_ff;
endmodule

// ===== sv/segment_intersection_xy.sv =====
`timescale 1ns / 1ps
// channel   ports                               transfer
// request   start, busy, req_*                  start && !busy
// response  rsp_valid, rsp_hit, rsp_cross_x/y   rsp_valid, one cycle
// one pair per cycle; the path runs through the front stages, the queue, the multiply
// stage, 17 divide stages and the output register
// busy stays low after reset; the back end never stalls, so the queue
// pops each pair in the cycle after it is pushed and never fills
// synchronous active-high reset clears all valid flags and queue pointers
module segment_intersection_xy (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  six_pkg::coord_type req_a_start_x,
   input  six_pkg::coord_type req_a_start_y,
   input  six_pkg::coord_type req_a_end_x,
   input  six_pkg::coord_type req_a_end_y,
   input  six_pkg::coord_type req_b_start_x,
   input  six_pkg::coord_type req_b_start_y,
   input  six_pkg::coord_type req_b_end_x,
   input  six_pkg::coord_type req_b_end_y,
   output logic rsp_valid,
   output logic rsp_hit,
   output six_pkg::coord_type rsp_cross_x,
   output six_pkg::coord_type rsp_cross_y
);
   import six_pkg::*;
`include "segment_intersection_xy_defines.svh"

   logic accept, f_valid, q_ne;
   job_type f_job, q_job;
   res_type res;

   assign busy = 1'b0;
   assign accept = start && !busy;

   six_front u_front (
      .clock(clock), .reset(reset), .in_valid(accept),
      .ax0(req_a_start_x), .ay0(req_a_start_y),
      .ax1(req_a_end_x), .ay1(req_a_end_y),
      .bx0(req_b_start_x), .by0(req_b_start_y),
      .bx1(req_b_end_x), .by1(req_b_end_y),
      .out_valid(f_valid), .out_job(f_job)
   );

   six_queue u_queue (
      .clock(clock), .reset(reset), .push(f_valid), .push_job(f_job),
      .pop(q_ne), .not_empty(q_ne), .head_job(q_job)
   );

   six_back u_back (
      .clock(clock), .reset(reset), .in_valid(q_ne), .in_job(q_job), .res(res)
   );

   assign rsp_valid = res.valid;
   assign rsp_hit = res.hit;
   assign rsp_cross_x = res.x;
   assign rsp_cross_y = res.y;

   `SIX_ASSERT_IMPL(a_miss_zero, clock, reset, rsp_valid && !rsp_hit,
      rsp_cross_x == '0 && rsp_cross_y == '0)
   `SIX_ASSERT_NEXT(a_queue_drains, clock, reset, q_ne && !f_valid, !q_ne)
   `SIX_ASSERT_IMPL(a_never_busy, clock, reset, 1'b1, !busy)
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import six_pkg::*;

   typedef struct packed {
      logic hit;
      coord_type x;
      coord_type y;
   } crossing_type;

   typedef struct packed {
      coord_type ax0;
      coord_type ay0;
      coord_type ax1;
      coord_type ay1;
      coord_type bx0;
      coord_type by0;
      coord_type bx1;
      coord_type by1;
   } segs_type;

   typedef struct packed {
      segs_type segs;
      logic typed;
      crossing_type want;
   } row_type;

   localparam int N_RANDOM = 1130;
   localparam int LIMIT_CYCLES = 300000;
   localparam int DRAIN_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_type req_a_start_x = '0, req_a_start_y = '0, req_a_end_x = '0, req_a_end_y = '0;
   coord_type req_b_start_x = '0, req_b_start_y = '0, req_b_end_x = '0, req_b_end_y = '0;
   logic rsp_valid, rsp_hit;
   coord_type rsp_cross_x, rsp_cross_y;

   crossing_type pending_cross[$];
   crossing_type typed_cross[$];
   logic typed_flag[$];
   logic next_typed = 1'b0;
   crossing_type next_want = '0;
   int accepted_cnt = 0;
   int errors = 0;
   int hits_seen = 0;
   int cycles = 0;

   segment_intersection_xy dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_start_x(req_a_start_x), .req_a_start_y(req_a_start_y),
      .req_a_end_x(req_a_end_x), .req_a_end_y(req_a_end_y),
      .req_b_start_x(req_b_start_x), .req_b_start_y(req_b_start_y),
      .req_b_end_x(req_b_end_x), .req_b_end_y(req_b_end_y),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // side test: sign of (p - o) against the left normal of (e - o)
   function automatic longint side_of(longint ox, longint oy, longint ex, longint ey,
                                      longint px, longint py);
      return (py - oy) * (ex - ox) - (px - ox) * (ey - oy);
   endfunction

   function automatic coord_type along_axis(longint s, longint e, longint unsigned w,
                                            longint unsigned den);
      longint diff;
      longint unsigned q;
      longint r;
      diff = e - s;
      q = (w * longint'(diff < 0 ? -diff : diff)) / den;
      r = diff < 0 ? s - longint'(q) : s + longint'(q);
      return r[COORD_BITS-1:0];
   endfunction

   function automatic crossing_type predict_crossing(segs_type g);
      crossing_type c;
      longint db0, db1, da0, da1;
      longint unsigned w, den;
      c = '0;
      db0 = side_of(g.ax0, g.ay0, g.ax1, g.ay1, g.bx0, g.by0);
      db1 = side_of(g.ax0, g.ay0, g.ax1, g.ay1, g.bx1, g.by1);
      if ((db0 > 0) == (db1 > 0)) return c;
      da0 = side_of(g.bx0, g.by0, g.bx1, g.by1, g.ax0, g.ay0);
      da1 = side_of(g.bx0, g.by0, g.bx1, g.by1, g.ax1, g.ay1);
      if ((da0 > 0) == (da1 > 0)) return c;
      w = da0 < 0 ? -da0 : da0;
      den = w + (da1 < 0 ? -da1 : da1);
      if (den == 0) return c;
      c.hit = 1'b1;
      c.x = along_axis(g.ax0, g.ax1, w, den);
      c.y = along_axis(g.ay0, g.ay1, w, den);
      return c;
   endfunction

   always @(posedge clock) begin
      crossing_type got, want;
      if (!reset) begin
         cycles <= cycles + 1;
         if (start && !busy) begin
            pending_cross.push_back(predict_crossing({req_a_start_x, req_a_start_y,
               req_a_end_x, req_a_end_y, req_b_start_x, req_b_start_y,
               req_b_end_x, req_b_end_y}));
            typed_flag.push_back(next_typed);
            typed_cross.push_back(next_want);
            accepted_cnt = accepted_cnt + 1;
         end
         if (rsp_valid) begin
            got = {rsp_hit, rsp_cross_x, rsp_cross_y};
            if (pending_cross.size() == 0) begin
               $error("result with no transaction outstanding");
               errors++;
            end else begin
               want = pending_cross.pop_front();
               if (typed_flag.pop_front()) want = typed_cross.pop_front();
               else void'(typed_cross.pop_front());
               if (got.hit) hits_seen++;
               if (got.hit !== want.hit) begin
                  $error("hit expected %0d actual %0d", want.hit, got.hit);
                  errors++;
               end
               if (got.x !== want.x) begin
                  $error("cross_x expected %0d actual %0d", want.x, got.x);
                  errors++;
               end
               if (got.y !== want.y) begin
                  $error("cross_y expected %0d actual %0d", want.y, got.y);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_pair(segs_type g, logic typed, crossing_type want);
      int gap;
      int seen_cnt;
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      {req_a_start_x, req_a_start_y, req_a_end_x, req_a_end_y,
       req_b_start_x, req_b_start_y, req_b_end_x, req_b_end_y} = g;
      next_typed = typed;
      next_want = want;
      start = 1'b1;
      seen_cnt = accepted_cnt;
      do @(negedge clock); while (accepted_cnt == seen_cnt);
   endtask

   function automatic coord_type boxed(int span);
      return coord_type'(int'($urandom_range(0, 2 * span - 1)) - span);
   endfunction

   function automatic segs_type random_pair();
      segs_type g;
      int span;
      g = {$urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(0, 3) != 0) begin
         // boxed endpoints, with opposite corners crossing more often
         span = 1 << $urandom_range(2, 15);
         g.ax0 = boxed(span);
         g.ay0 = boxed(span);
         g.ax1 = boxed(span);
         g.ay1 = boxed(span);
         g.bx0 = boxed(span);
         g.by0 = boxed(span);
         g.bx1 = boxed(span);
         g.by1 = boxed(span);
         if ($urandom_range(0, 1)) begin
            g.bx0 = g.ax0; g.by0 = g.ay1;
            g.bx1 = g.ax1; g.by1 = g.ay0;
         end
      end
      return g;
   endfunction

   localparam coord_type MX = 16'sh7fff;
   localparam coord_type MN = -16'sh8000;
   localparam crossing_type NO_HIT = '0;

   row_type rows[20] = '{
      '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, NO_HIT},
      '{'{MX, MX, MX, MX, MX, MX, MX, MX}, 1'b1, NO_HIT},
      '{'{MN, MN, MN, MN, MN, MN, MN, MN}, 1'b1, NO_HIT},
      // zero-length A
      '{'{16'sh100, 16'sh100, 16'sh100, 16'sh100, 0, 16'sh200, 16'sh200, 0}, 1'b1, NO_HIT},
      // zero-length B
      '{'{0, 0, 16'sh200, 16'sh200, 16'sh100, 16'sh100, 16'sh100, 16'sh100}, 1'b1, NO_HIT},
      // collinear overlap
      '{'{0, 0, 16'sh400, 0, 16'sh100, 0, 16'sh300, 0}, 1'b1, NO_HIT},
      // parallel
      '{'{0, 0, 16'sh400, 0, 0, 16'sh100, 16'sh400, 16'sh100}, 1'b1, NO_HIT},
      // plain X crossing at (0x100, 0x100)
      '{'{0, 0, 16'sh200, 16'sh200, 0, 16'sh200, 16'sh200, 0}, 1'b1,
        '{1'b1, 16'sh100, 16'sh100}},
      // B reversed
      '{'{0, 0, 16'sh200, 16'sh200, 16'sh200, 0, 0, 16'sh200}, 1'b0, NO_HIT},
      // B starts on A
      '{'{0, 0, 16'sh200, 0, 16'sh100, 0, 16'sh100, 16'sh100}, 1'b0, NO_HIT},
      // B ends on A
      '{'{0, 0, 16'sh200, 0, 16'sh100, 16'sh100, 16'sh100, 0}, 1'b0, NO_HIT},
      // A and B cross at their common midpoint
      '{'{0, 0, 16'sh100, 16'sh100, 0, 16'sh100, 16'sh100, 0}, 1'b0, NO_HIT},
      // lines cross outside segments
      '{'{0, 0, 16'sh100, 16'sh100, 16'sh400, 16'sh300, 16'sh300, 16'sh400}, 1'b1, NO_HIT},
      // full-range diagonals and axes, then other pairs
      '{'{MN, MN, MX, MX, MN, MX, MX, MN}, 1'b0, NO_HIT},
      '{'{MX, MX, MN, MN, MX, MN, MN, MX}, 1'b0, NO_HIT},
      '{'{MN, 0, MX, 0, 0, MN, 0, MX}, 1'b0, NO_HIT},
      '{'{MN, MX, MX, MN, MN, MN, MX, MX}, 1'b0, NO_HIT},
      '{'{MN, MN, MX, MN + 1, 0, MN, 1, MX}, 1'b0, NO_HIT},
      '{'{-1, -1, 1, 1, -1, 1, 1, -1}, 1'b0, NO_HIT},
      '{'{MN, 16'sh0001, MX, -16'sh0001, 16'sh0003, MN, -16'sh0002, MX}, 1'b0, NO_HIT}
   };

   initial begin
      repeat (4) @(negedge clock);
      reset = 1'b0;
      foreach (rows[i]) send_pair(rows[i].segs, rows[i].typed, rows[i].want);
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 2) begin
            start = 1'b0;
            while (pending_cross.size() != 0) @(negedge clock);
         end
         send_pair(random_pair(), 1'b0, NO_HIT);
      end
      start = 1'b0;
      while (pending_cross.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d segment pairs, %0d crossings reported", accepted_cnt, hits_seen);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
